### sv/jfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jfss_pkg;

  localparam int WORD_BITS          = 64;
  localparam int LOCAL_SLOTS_DEF    = 256;
  localparam int STACK_ENTRIES_DEF  = 64;

  typedef enum logic [2:0] {
    ACT_WR_LOCAL = 3'd0,
    ACT_RD_LOCAL = 3'd1,
    ACT_PUSH     = 3'd2,
    ACT_POP      = 3'd3,
    ACT_PEEK     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  localparam logic [2:0] KIND_EMPTY = 3'd0;
  localparam logic [2:0] KIND_I32   = 3'd1;
  localparam logic [2:0] KIND_I64   = 3'd2;
  localparam logic [2:0] KIND_F32   = 3'd3;
  localparam logic [2:0] KIND_F64   = 3'd4;
  localparam logic [2:0] KIND_OREF  = 3'd5;
  localparam logic [2:0] KIND_AREF  = 3'd6;
  localparam logic [2:0] KIND_TAIL  = 3'd7;

  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_LOCAL_RANGE = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW   = 3'd2;
  localparam logic [2:0] ERR_FULL        = 3'd3;
  localparam logic [2:0] ERR_CAPACITY    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WR,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [2:0]           action;
    logic [7:0]           slot_index;
    logic [5:0]           stack_depth_sel;
    logic [WORD_BITS-1:0] value_word;
    logic [2:0]           value_kind;
  } in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_word;
    logic [2:0]           read_kind;
    logic [2:0]           error_code;
    logic [8:0]           locals_in_use;
    logic [6:0]           stack_count;
  } out_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [WORD_BITS-1:0] word;
  } stk_ent_t;

  function automatic logic is_cat2(input logic [2:0] kind);
    return (kind == KIND_I64) || (kind == KIND_F64);
  endfunction

  function automatic logic kind_ok(input logic [2:0] kind);
    return (kind != KIND_EMPTY) && (kind != KIND_TAIL);
  endfunction

endpackage
`default_nettype wire

### sv/jvm_frame_slot_and_stack_store_unit.sv
// Flow: a word is accepted in idle, decoded in the exec state and its result loaded into
// the output register, via the hold state while the output stalls; a local write that must
// retag neighboring slots first does each extra tag write in the tag-write state. No new
// word is taken until the last one has left the state machine; the slot tag memory has a single write port.
// Reset: clears the state machine, slot and stack counts and all slot valid flags at once;
// the value and stack memories are not initialized.
`timescale 1ns / 1ps
`default_nettype none
module jvm_frame_slot_and_stack_store_unit
  import jfss_pkg::*;
#(
  parameter int LOCAL_SLOTS   = LOCAL_SLOTS_DEF,
  parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int LAW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
  localparam int LUW = $clog2(LOCAL_SLOTS + 1);
  localparam int SAW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int SCW = $clog2(STACK_ENTRIES + 1);

  // memories
  logic [2:0]           kind_mem [LOCAL_SLOTS];
  logic [WORD_BITS-1:0] val_mem  [LOCAL_SLOTS];
  stk_ent_t             stk_mem  [STACK_ENTRIES];

  state_t               state_r, state_nxt;
  in_t                  item_r;
  logic [LUW-1:0]       used_r, used_nxt;
  logic [SCW-1:0]       top_r, top_nxt;
  logic [LOCAL_SLOTS-1:0] vld_r;
  logic                 vld_a_r, vld_b_r;
  logic [2:0]           kmem_a_r, kmem_b_r;
  logic [WORD_BITS-1:0] vmem_r;
  stk_ent_t             smem_r;
  out_t                 res_r, res;
  logic                 wp_prev_r, wp_prev_nxt;
  logic                 wp_mid_r, wp_mid_nxt;
  logic                 wp_far_r, wp_far_nxt;
  logic [2:0]           mid_kind_r, mid_kind_nxt;
  logic                 out_vld_r;
  out_t                 out_r;

  logic                 acc;
  logic [LAW-1:0]       ka_addr, kb_addr;
  logic [SAW-1:0]       s_raddr, s_waddr;
  logic                 k_we, v_we, s_we, vld_clr, out_load;
  logic [LAW-1:0]       k_waddr;
  logic [2:0]           k_wdata;
  out_t                 out_ld_data;

  assign acc = in_valid && !in_stall;

  // read addresses come straight from the incoming word
  always_comb begin
    logic [31:0] sub;
    sub     = (in_data.action == ACT_PEEK) ? 32'(in_data.stack_depth_sel) : 32'd0;
    ka_addr = LAW'(in_data.slot_index);
    kb_addr = LAW'(32'(in_data.slot_index) + (is_cat2(in_data.value_kind) ? 32'd1 : 32'd0));
    s_raddr = SAW'(32'(top_r) - 32'd1 - sub);
  end

  assign s_waddr = SAW'(top_r);

  always_ff @(posedge clk) begin
    if (acc) begin
      kmem_a_r <= kind_mem[ka_addr];
      kmem_b_r <= kind_mem[kb_addr];
      vmem_r   <= val_mem[ka_addr];
      smem_r   <= stk_mem[s_raddr];
      vld_a_r  <= vld_r[ka_addr];
      vld_b_r  <= vld_r[kb_addr];
      item_r   <= in_data;
    end
    if (k_we) kind_mem[k_waddr] <= k_wdata;
    if (v_we) val_mem[LAW'(item_r.slot_index)] <= item_r.value_word;
    if (s_we) stk_mem[s_waddr] <= '{kind: item_r.value_kind, word: item_r.value_word};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      top_r     <= '0;
      vld_r     <= '0;
      wp_prev_r <= 1'b0;
      wp_mid_r  <= 1'b0;
      wp_far_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      top_r     <= top_nxt;
      wp_prev_r <= wp_prev_nxt;
      wp_mid_r  <= wp_mid_nxt;
      wp_far_r  <= wp_far_nxt;
      if (vld_clr) begin
        vld_r <= '0;
      end else if (k_we) begin
        vld_r[k_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mid_kind_r <= mid_kind_nxt;
    if (state_r == ST_EXEC) res_r <= res;
    if (out_load) out_r <= out_ld_data;
  end

  always_comb begin
    logic [2:0]  kind_a, kind_b;
    logic [31:0] idx32, u32, t32, n32, end32;
    logic        out_free, c2, more;
    kind_a   = vld_a_r ? kmem_a_r : KIND_EMPTY;
    kind_b   = vld_b_r ? kmem_b_r : KIND_EMPTY;
    idx32    = 32'(item_r.slot_index);
    u32      = 32'(used_r);
    t32      = 32'(top_r);
    c2       = is_cat2(item_r.value_kind);
    n32      = c2 ? 32'd2 : 32'd1;
    end32    = idx32 + n32;
    out_free = !out_vld_r || !out_stall;
    more     = 1'b0;

    state_nxt    = state_r;
    in_stall     = (state_r != ST_IDLE);
    used_nxt     = used_r;
    top_nxt      = top_r;
    wp_prev_nxt  = wp_prev_r;
    wp_mid_nxt   = wp_mid_r;
    wp_far_nxt   = wp_far_r;
    mid_kind_nxt = mid_kind_r;
    k_we         = 1'b0;
    k_waddr      = LAW'(item_r.slot_index);
    k_wdata      = item_r.value_kind;
    v_we         = 1'b0;
    s_we         = 1'b0;
    vld_clr      = 1'b0;
    out_load     = 1'b0;
    out_ld_data  = res_r;
    res          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res.error_code = ERR_OK;
        case (item_r.action)
          ACT_WR_LOCAL: begin
            if (kind_ok(item_r.value_kind)) begin
              if (end32 > 32'(LOCAL_SLOTS)) begin
                res.error_code = ERR_CAPACITY;
              end else begin
                k_we        = 1'b1;
                v_we        = 1'b1;
                // break a pair whose tail this write lands on
                wp_prev_nxt = (kind_a == KIND_TAIL) && (idx32 != 32'd0);
                if (c2) begin
                  wp_mid_nxt   = 1'b1;
                  mid_kind_nxt = KIND_TAIL;
                  wp_far_nxt   = is_cat2(kind_b) && (idx32 + 32'd2 < u32);
                end else begin
                  wp_mid_nxt   = is_cat2(kind_a) && (idx32 + 32'd1 < u32);
                  mid_kind_nxt = KIND_EMPTY;
                  wp_far_nxt   = 1'b0;
                end
                if (end32 > u32) used_nxt = LUW'(end32);
              end
            end
          end
          ACT_RD_LOCAL: begin
            if (idx32 >= u32 || idx32 >= 32'(LOCAL_SLOTS)) begin
              res.error_code = ERR_LOCAL_RANGE;
            end else begin
              res.read_kind = kind_a;
              res.read_word = kind_ok(kind_a) ? vmem_r : '0;
            end
          end
          ACT_PUSH: begin
            if (kind_ok(item_r.value_kind)) begin
              if (t32 >= 32'(STACK_ENTRIES)) begin
                res.error_code = ERR_FULL;
              end else begin
                s_we    = 1'b1;
                top_nxt = SCW'(t32 + 32'd1);
              end
            end
          end
          ACT_POP: begin
            if (t32 == 32'd0) begin
              res.error_code = ERR_UNDERFLOW;
            end else begin
              top_nxt       = SCW'(t32 - 32'd1);
              res.read_word = smem_r.word;
              res.read_kind = smem_r.kind;
            end
          end
          ACT_PEEK: begin
            if (32'(item_r.stack_depth_sel) >= t32) begin
              res.error_code = ERR_UNDERFLOW;
            end else begin
              res.read_word = smem_r.word;
              res.read_kind = smem_r.kind;
            end
          end
          ACT_CLEAR: begin
            vld_clr  = 1'b1;
            used_nxt = '0;
            top_nxt  = '0;
          end
          default: ;
        endcase
        res.locals_in_use = 9'(used_nxt);
        res.stack_count   = 7'(top_nxt);
        out_ld_data       = res;
        if (wp_prev_nxt || wp_mid_nxt || wp_far_nxt) begin
          state_nxt = ST_WR;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_WR: begin
        // one tag write per cycle: left partner, then right slot, then far partner
        k_we = 1'b1;
        priority if (wp_prev_r) begin
          k_waddr     = LAW'(idx32 - 32'd1);
          k_wdata     = KIND_EMPTY;
          wp_prev_nxt = 1'b0;
          more        = wp_mid_r || wp_far_r;
        end else if (wp_mid_r) begin
          k_waddr    = LAW'(idx32 + 32'd1);
          k_wdata    = mid_kind_r;
          wp_mid_nxt = 1'b0;
          more       = wp_far_r;
        end else begin
          k_waddr    = LAW'(idx32 + 32'd2);
          k_wdata    = KIND_EMPTY;
          wp_far_nxt = 1'b0;
        end
        if (more) begin
          state_nxt = ST_WR;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### tb/jvm_frame_slot_and_stack_store_unit_tb.sv
`timescale 1ns / 1ps
module jvm_frame_slot_and_stack_store_unit_tb;
  import jfss_pkg::*;

  localparam int unsigned N_SLOTS      = 256;
  localparam int unsigned N_ENTRIES    = 64;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned PHASE_ITEMS  = 340;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [2:0]  ACT_NOP_LO   = 3'd6;
  localparam logic [2:0]  ACT_NOP_HI   = 3'd7;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // expectation typed into the directed table, travels with the word
  bit   cur_fixed = 1'b0;
  out_t cur_want = '0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  bit          pressure_req = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;

  // frame shadow state
  logic [63:0] lv_word [N_SLOTS];
  logic [2:0]  lv_kind [N_SLOTS];
  int unsigned lv_used = 0;
  logic [63:0] opnd_word [N_ENTRIES];
  logic [2:0]  opnd_kind [N_ENTRIES];
  int unsigned opnd_top = 0;

  out_t     frame_results_q [$];
  dir_row_t dir_tab [$];

  jvm_frame_slot_and_stack_store_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void lv_empty(int unsigned i);
    lv_kind[i] = KIND_EMPTY;
    lv_word[i] = '0;
  endfunction

  // empty a slot range in use, breaking any long/double pair it touches
  function automatic void lv_break_range(int unsigned first, int unsigned cnt);
    logic [2:0] k;
    for (int unsigned i = first; i < first + cnt && i < lv_used; i++) begin
      k = lv_kind[i];
      if (k != KIND_EMPTY) begin
        if (k == KIND_TAIL && i > 0) lv_empty(i - 1);
        if ((k == KIND_I64 || k == KIND_F64) && i + 1 < lv_used) lv_empty(i + 1);
        lv_empty(i);
      end
    end
  endfunction

  function automatic out_t frame_step(in_t w);
    out_t        r;
    int unsigned idx;
    int unsigned span;
    int unsigned pos;
    bit          kind_good;
    r = '0;
    idx = w.slot_index;
    kind_good = (w.value_kind != KIND_EMPTY) && (w.value_kind != KIND_TAIL);
    case (w.action)
      ACT_WR_LOCAL: begin
        span = (w.value_kind == KIND_I64 || w.value_kind == KIND_F64) ? 2 : 1;
        if (kind_good) begin
          if (idx + span > N_SLOTS) begin
            r.error_code = ERR_CAPACITY;
          end else begin
            lv_break_range(idx, span);
            if (idx + span > lv_used) lv_used = idx + span;
            lv_word[idx] = w.value_word;
            lv_kind[idx] = w.value_kind;
            if (span == 2) begin
              lv_word[idx + 1] = '0;
              lv_kind[idx + 1] = KIND_TAIL;
            end
          end
        end
      end
      ACT_RD_LOCAL: begin
        if (idx >= lv_used) begin
          r.error_code = ERR_LOCAL_RANGE;
        end else begin
          r.read_kind = lv_kind[idx];
          if (lv_kind[idx] != KIND_EMPTY && lv_kind[idx] != KIND_TAIL)
            r.read_word = lv_word[idx];
        end
      end
      ACT_PUSH: begin
        if (kind_good) begin
          if (opnd_top >= N_ENTRIES) begin
            r.error_code = ERR_FULL;
          end else begin
            opnd_word[opnd_top] = w.value_word;
            opnd_kind[opnd_top] = w.value_kind;
            opnd_top++;
          end
        end
      end
      ACT_POP: begin
        if (opnd_top == 0) begin
          r.error_code = ERR_UNDERFLOW;
        end else begin
          opnd_top--;
          r.read_word = opnd_word[opnd_top];
          r.read_kind = opnd_kind[opnd_top];
        end
      end
      ACT_PEEK: begin
        if (w.stack_depth_sel >= opnd_top) begin
          r.error_code = ERR_UNDERFLOW;
        end else begin
          pos = opnd_top - 1 - w.stack_depth_sel;
          r.read_word = opnd_word[pos];
          r.read_kind = opnd_kind[pos];
        end
      end
      ACT_CLEAR: begin
        for (int unsigned i = 0; i < N_SLOTS; i++) lv_empty(i);
        lv_used = 0;
        opnd_top = 0;
      end
      default: ;
    endcase
    r.locals_in_use = lv_used[8:0];
    r.stack_count = opnd_top[6:0];
    return r;
  endfunction

  function automatic in_t mk_in(logic [2:0] act, logic [7:0] idx, logic [5:0] dep,
                                logic [63:0] word, logic [2:0] kind);
    in_t w;
    w.action = act;
    w.slot_index = idx;
    w.stack_depth_sel = dep;
    w.value_word = word;
    w.value_kind = kind;
    return w;
  endfunction

  function automatic out_t mk_out(logic [63:0] word, logic [2:0] kind, logic [2:0] err,
                                  logic [8:0] used, logic [6:0] cnt);
    out_t r;
    r.read_word = word;
    r.read_kind = kind;
    r.error_code = err;
    r.locals_in_use = used;
    r.stack_count = cnt;
    return r;
  endfunction

  function automatic void add_row(in_t w, bit fixed, out_t want);
    dir_row_t row;
    row.item = w;
    row.fixed = fixed;
    row.want = want;
    dir_tab = {dir_tab, row};
  endfunction

  // mode 0 fills the stack, 1 drains it, 2 keeps it balanced
  function automatic in_t gen_item(int unsigned mode);
    in_t         w;
    int unsigned p;
    int unsigned t0, t1, t2, t3;
    case (mode)
      0:       begin t0 = 20; t1 = 35; t2 = 80; t3 = 88; end
      1:       begin t0 = 20; t1 = 40; t2 = 55; t3 = 85; end
      default: begin t0 = 25; t1 = 50; t2 = 70; t3 = 85; end
    endcase
    p = $urandom_range(999);
    if (p < 5)       w.action = ACT_CLEAR;
    else if (p < 12) w.action = ACT_NOP_LO;
    else if (p < 20) w.action = ACT_NOP_HI;
    else begin
      p = $urandom_range(99);
      if (p < t0)      w.action = ACT_WR_LOCAL;
      else if (p < t1) w.action = ACT_RD_LOCAL;
      else if (p < t2) w.action = ACT_PUSH;
      else if (p < t3) w.action = ACT_POP;
      else             w.action = ACT_PEEK;
    end
    p = $urandom_range(99);
    if (p < 60)      w.slot_index = 8'($urandom_range(15));
    else if (p < 85) w.slot_index = 8'($urandom_range(255));
    else             w.slot_index = 8'($urandom_range(255, 250));
    w.stack_depth_sel = ($urandom_range(99) < 70) ? 6'($urandom_range(7))
                                                  : 6'($urandom_range(63));
    w.value_word = {$urandom, $urandom};
    if ($urandom_range(99) < 92) w.value_kind = 3'($urandom_range(6, 1));
    else                         w.value_kind = $urandom_range(1) ? KIND_TAIL : KIND_EMPTY;
    return w;
  endfunction

  task automatic send_word(in_t w, bit fixed, out_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    cur_fixed <= fixed;
    cur_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (frame_results_q.size() == 0) begin
      $error("unexpected result word: %h", got);
      mismatches++;
    end else begin
      want = frame_results_q.pop_front();
      if (got.read_word !== want.read_word) begin
        $error("read_word: expected %h, got %h", want.read_word, got.read_word);
        mismatches++;
      end
      if (got.read_kind !== want.read_kind) begin
        $error("read_kind: expected %0d, got %0d", want.read_kind, got.read_kind);
        mismatches++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        mismatches++;
      end
      if (got.locals_in_use !== want.locals_in_use) begin
        $error("locals_in_use: expected %0d, got %0d", want.locals_in_use, got.locals_in_use);
        mismatches++;
      end
      if (got.stack_count !== want.stack_count) begin
        $error("stack_count: expected %0d, got %0d", want.stack_count, got.stack_count);
        mismatches++;
      end
    end
  endtask

  // predict on every accepted word, in acceptance order
  always @(posedge clk) begin
    out_t pred;
    if (rst_n && in_valid && !in_stall) begin
      pred = frame_step(in_data);
      frame_results_q = {frame_results_q, (cur_fixed ? cur_want : pred)};
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (pressure_req && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL jvm_frame_slot_and_stack_store_unit");
      $finish;
    end
  end

  initial begin
    in_t         w;
    int unsigned live;
    int unsigned sent;
    int unsigned mode;
    int unsigned phase;
    int unsigned pick;

    // frame starts with every slot empty
    for (int unsigned i = 0; i < N_SLOTS; i++) lv_empty(i);

    // empty frame: every access errors, bad kinds and spare opcodes do nothing
    add_row(mk_in(ACT_RD_LOCAL, 8'd0, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_LOCAL_RANGE, 9'd0, 7'd0));
    add_row(mk_in(ACT_POP, 8'd0, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_UNDERFLOW, 9'd0, 7'd0));
    add_row(mk_in(ACT_PEEK, 8'd0, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_UNDERFLOW, 9'd0, 7'd0));
    add_row(mk_in(ACT_WR_LOCAL, 8'd255, 6'd0, '1, KIND_I64), 1,
            mk_out('0, KIND_EMPTY, ERR_CAPACITY, 9'd0, 7'd0));
    add_row(mk_in(ACT_WR_LOCAL, 8'd0, 6'd0, '1, KIND_EMPTY), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd0, 7'd0));
    add_row(mk_in(ACT_PUSH, 8'd0, 6'd0, '1, KIND_TAIL), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd0, 7'd0));
    add_row(mk_in(ACT_NOP_LO, 8'd255, 6'd63, '1, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd0, 7'd0));
    add_row(mk_in(ACT_NOP_HI, 8'd255, 6'd63, '1, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd0, 7'd0));
    // double at the top of the slot file: head, tail, and exposed empty slots
    add_row(mk_in(ACT_WR_LOCAL, 8'd254, 6'd0, '1, KIND_F64), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd256, 7'd0));
    add_row(mk_in(ACT_RD_LOCAL, 8'd254, 6'd0, '0, KIND_I32), 1,
            mk_out('1, KIND_F64, ERR_OK, 9'd256, 7'd0));
    add_row(mk_in(ACT_RD_LOCAL, 8'd255, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_TAIL, ERR_OK, 9'd256, 7'd0));
    add_row(mk_in(ACT_RD_LOCAL, 8'd100, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd256, 7'd0));
    // overwrite the tail, then write a long and overwrite its tail: both break their pairs
    add_row(mk_in(ACT_WR_LOCAL, 8'd255, 6'd0, 64'h0123_4567_89ab_cdef, KIND_F32), 0, '0);
    add_row(mk_in(ACT_RD_LOCAL, 8'd254, 6'd0, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_RD_LOCAL, 8'd255, 6'd0, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_WR_LOCAL, 8'd0, 6'd0, 64'h8000_0000_0000_0000, KIND_I64), 0, '0);
    add_row(mk_in(ACT_WR_LOCAL, 8'd1, 6'd0, 64'h7fff_ffff_ffff_ffff, KIND_OREF), 0, '0);
    add_row(mk_in(ACT_RD_LOCAL, 8'd0, 6'd0, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_RD_LOCAL, 8'd1, 6'd0, '0, KIND_I32), 0, '0);
    // stack: a double takes one entry, peek in range and too deep
    add_row(mk_in(ACT_PUSH, 8'd0, 6'd0, '1, KIND_AREF), 0, '0);
    add_row(mk_in(ACT_PUSH, 8'd0, 6'd0, '0, KIND_F64), 0, '0);
    add_row(mk_in(ACT_PEEK, 8'd0, 6'd1, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_PEEK, 8'd0, 6'd63, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_POP, 8'd0, 6'd0, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_POP, 8'd0, 6'd0, '0, KIND_I32), 0, '0);
    add_row(mk_in(ACT_CLEAR, 8'd0, 6'd0, '0, KIND_I32), 1,
            mk_out('0, KIND_EMPTY, ERR_OK, 9'd0, 7'd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

    live = 0;
    sent = 0;
    mode = 2;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin snd_idle_pct <= 0;  rcv_stall_pct <= 0;  end
        1:       begin snd_idle_pct <= 82; rcv_stall_pct <= 0;  end
        2:       begin snd_idle_pct <= 0;  rcv_stall_pct <= 82; end
        3:       begin snd_idle_pct <= 22; rcv_stall_pct <= 22; end
        default: ;
      endcase
      while (live < (phase + 1) * PHASE_ITEMS && live < RANDOM_ITEMS) begin
        if (sent % 64 == 0) mode = $urandom_range(2);
        // last phase: hop between idle settings, with quiet stretches
        if (phase == 4 && sent % 50 == 0) begin
          pick = $urandom_range(3);
          snd_idle_pct <= (pick == 1) ? 82 : (pick == 3) ? 22 : 0;
          rcv_stall_pct <= (pick == 2) ? 82 : (pick == 3) ? 22 : 0;
        end
        if (phase == 0 && live == 100) pressure_req <= 1'b1;
        w = gen_item(mode);
        send_word(w, 1'b0, '0);
        sent++;
        if (!(w.action == ACT_NOP_LO || w.action == ACT_NOP_HI ||
              ((w.action == ACT_WR_LOCAL || w.action == ACT_PUSH) &&
               (w.value_kind == KIND_EMPTY || w.value_kind == KIND_TAIL))))
          live++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("PASS jvm_frame_slot_and_stack_store_unit");
    else
      $display("FAIL jvm_frame_slot_and_stack_store_unit");
    $finish;
  end

endmodule
